// ===== src/assert_macros.svh =====
// Assertion macros for the deque RTL.
// Taken in by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_NOW(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/cded_pkg.sv =====
// Shared constants for the circular double-ended queue.
// No dependencies; used by the interfaces, cded_store, the top level and the bench.
`timescale 1ns / 1ps
package cded_pkg;
    localparam int WORD_BITS   = 32;
    localparam int ACTION_BITS = 3;
    localparam int STATUS_BITS = 2;
    localparam int DEPTH_DEF   = 8;

    localparam logic [ACTION_BITS-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_READ_ALL   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
endpackage

// ===== src/cded_if.sv =====
// Valid/ready channels for deque requests and results.
// Depends on cded_pkg for field widths.
`timescale 1ns / 1ps
interface cded_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [cded_pkg::ACTION_BITS-1:0]    action;
    logic signed [cded_pkg::WORD_BITS-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cded_res_if;
    logic                                valid;
    logic                                ready;
    logic [cded_pkg::STATUS_BITS-1:0]    status;
    logic signed [cded_pkg::WORD_BITS-1:0] word;
    logic                                last;

    modport source (output valid, output status, output word, output last, input ready);
    modport sink   (input valid, input status, input word, input last, output ready);
endinterface

// ===== src/cded_step.sv =====
// Shared circular pointer step unit: one increment or decrement modulo DEPTH
// and the compares the sequencer needs. No package dependencies.
`timescale 1ns / 1ps
module cded_step #(
    parameter int DEPTH = 8,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic [PTR_W-1:0] i_ptr,
    input  logic             i_dec,
    input  logic [PTR_W-1:0] i_cmp,
    output logic [PTR_W-1:0] o_step,
    output logic             o_step_hit,
    output logic             o_at_cmp
);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    always_comb begin
        if (i_dec) begin
            o_step = (i_ptr == '0) ? LAST : i_ptr - PTR_W'(1);
        end else begin
            o_step = (i_ptr == LAST) ? '0 : i_ptr + PTR_W'(1);
        end
    end

    assign o_step_hit = (o_step == i_cmp);
    assign o_at_cmp   = (i_ptr == i_cmp);
endmodule

// ===== src/cded_store.sv =====
// Slot memory of the deque: one write port, one registered read port.
// Depends on cded_pkg for the word width.
`timescale 1ns / 1ps
module cded_store #(
    parameter int DEPTH = 8,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [PTR_W-1:0]                      i_wr_addr,
    input  logic signed [cded_pkg::WORD_BITS-1:0] i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [PTR_W-1:0]                      i_rd_addr,
    output logic signed [cded_pkg::WORD_BITS-1:0] o_rd_data
);
    logic signed [cded_pkg::WORD_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

// ===== src/circular_double_ended_queue.sv =====
// Circular double-ended queue: top level with the sequencer and pointer state.
// Depends on cded_pkg, cded_if, cded_step, cded_store and assert_macros.svh.
// Requests arrive on i_cmd (action, push_value) and results leave on o_res
// (status, word, last), both valid/ready. One request is handled at a time;
// i_cmd.ready is high only while the block is idle.
// After a request is accepted the block passes through S_DECODE; a push, a refused
// request or an empty read-out then goes straight to S_SEND with its result; a pop
// reads its slot in S_FETCH first; a non-empty read-out steps S_WALK, S_FETCH and
// S_SEND for each entry, moving on to the next entry once each result is taken. Each
// entry costs a trip through the registered read port of the slot memory. Actions 5
// to 7 give no result and the block returns from S_DECODE to S_IDLE.
// The block takes a new request the cycle after its final result is taken.
// Reset empties the queue; memory contents are not cleared.
// A stalled receiver holds the result and the block waits on it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module circular_double_ended_queue #(
    parameter int DEPTH = cded_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cded_cmd_if.sink        i_cmd,
    cded_res_if.source      o_res
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] CNT_LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WALK   = 5'b00100,
        S_FETCH  = 5'b01000,
        S_SEND   = 5'b10000
    } t_state;

    t_state                                r_state, n_state;
    logic [PTR_W-1:0]                      r_head, n_head;
    logic [PTR_W-1:0]                      r_tail, n_tail;
    logic                                  r_empty, n_empty;
    logic [cded_pkg::ACTION_BITS-1:0]      r_action;
    logic signed [cded_pkg::WORD_BITS-1:0] r_value;
    logic [PTR_W-1:0]                      r_walk;
    logic [PTR_W-1:0]                      r_count;
    logic [cded_pkg::STATUS_BITS-1:0]      r_status, n_status;
    logic signed [cded_pkg::WORD_BITS-1:0] r_word, n_word;
    logic                                  r_last, n_last;

    logic                                  ld_out, walk_load, walk_adv;
    logic                                  is_front, is_push;
    logic [PTR_W-1:0]                      st_ptr, st_cmp, st_step;
    logic                                  st_dec, st_hit, st_at;
    logic                                  wr_en, rd_en;
    logic [PTR_W-1:0]                      wr_addr, rd_addr;
    logic signed [cded_pkg::WORD_BITS-1:0] rd_data;

    assign is_front = (r_action == cded_pkg::ACT_PUSH_FRONT)
                   || (r_action == cded_pkg::ACT_POP_FRONT);
    assign is_push  = (r_action == cded_pkg::ACT_PUSH_FRONT)
                   || (r_action == cded_pkg::ACT_PUSH_REAR);

    always_comb begin
        if (r_action == cded_pkg::ACT_READ_ALL) begin
            st_ptr = r_walk;
            st_cmp = r_tail;
            st_dec = 1'b0;
        end else begin
            st_ptr = is_front ? r_head : r_tail;
            st_cmp = is_front ? r_tail : r_head;
            st_dec = (is_push && is_front) || (!is_push && !is_front);
        end
    end

    cded_step #(.DEPTH(DEPTH), .PTR_W(PTR_W)) u_step (
        .i_ptr      (st_ptr),
        .i_dec      (st_dec),
        .i_cmp      (st_cmp),
        .o_step     (st_step),
        .o_step_hit (st_hit),
        .o_at_cmp   (st_at)
    );

    cded_store #(.DEPTH(DEPTH), .PTR_W(PTR_W)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        wr_en     = 1'b0;
        wr_addr   = st_step;
        rd_en     = 1'b0;
        rd_addr   = st_ptr;
        ld_out    = 1'b0;
        n_status  = cded_pkg::ST_DONE;
        n_word    = '0;
        n_last    = 1'b1;
        walk_load = 1'b0;
        walk_adv  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_SEND;
                unique case (r_action)
                    cded_pkg::ACT_PUSH_FRONT, cded_pkg::ACT_PUSH_REAR: begin
                        ld_out = 1'b1;
                        if (r_empty) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b0;
                            wr_en   = 1'b1;
                            wr_addr = '0;
                        end else if (st_hit) begin
                            n_status = cded_pkg::ST_FULL;
                        end else begin
                            wr_en = 1'b1;
                            if (is_front) begin
                                n_head = st_step;
                            end else begin
                                n_tail = st_step;
                            end
                        end
                    end
                    cded_pkg::ACT_POP_FRONT, cded_pkg::ACT_POP_REAR: begin
                        if (r_empty) begin
                            ld_out   = 1'b1;
                            n_status = cded_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_FETCH;
                            if (st_at) begin
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b1;
                            end else if (is_front) begin
                                n_head = st_step;
                            end else begin
                                n_tail = st_step;
                            end
                        end
                    end
                    cded_pkg::ACT_READ_ALL: begin
                        if (r_empty) begin
                            ld_out   = 1'b1;
                            n_status = cded_pkg::ST_EMPTY;
                        end else begin
                            walk_load = 1'b1;
                            n_state   = S_WALK;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                rd_en   = 1'b1;
                rd_addr = r_walk;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                ld_out  = 1'b1;
                n_word  = rd_data;
                n_last  = (r_action != cded_pkg::ACT_READ_ALL) || st_at
                       || (r_count == CNT_LAST);
                n_state = S_SEND;
            end
            S_SEND: begin
                if (o_res.ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        walk_adv = 1'b1;
                        n_state  = S_WALK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_action <= i_cmd.action;
            r_value  <= i_cmd.push_value;
        end
        if (ld_out) begin
            r_status <= n_status;
            r_word   <= n_word;
            r_last   <= n_last;
        end
        if (walk_load) begin
            r_walk  <= r_head;
            r_count <= '0;
        end else if (walk_adv) begin
            r_walk  <= st_step;
            r_count <= r_count + PTR_W'(1);
        end
    end

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_SEND);
    assign o_res.status = r_status;
    assign o_res.word   = r_word;
    assign o_res.last   = r_last;

    `ASSERT_NOW(a_empty_ptrs, i_clk, i_rst_n, r_empty, (r_head == '0) && (r_tail == '0), "empty queue with stray pointers")
    `ASSERT_NOW(a_err_word, i_clk, i_rst_n, o_res.valid && (o_res.status != cded_pkg::ST_DONE), (o_res.word == '0) && o_res.last, "refusal result not single or carries a word")
    `ASSERT_NOW(a_walk_bound, i_clk, i_rst_n, o_res.valid && !o_res.last, r_count != CNT_LAST, "read-out ran past the store depth")
    `ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, (r_state == S_DECODE) && !o_res.valid, "accepted item not decoded")
endmodule

// ===== bench/circular_double_ended_queue_tb.sv =====
// Self-checking bench for circular_double_ended_queue: a directed table, then random
// push, pop, read-out and spare-action items under random idling on both channels.
// Depends on cded_pkg, cded_if and the block itself.
`timescale 1ns / 1ps
module circular_double_ended_queue_tb;
    import cded_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 400;
    localparam int MODE_SPAN      = 30;
    localparam int HOLD_AT_RESULT = 60;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [ACTION_BITS-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_C = 3'd7;

    typedef logic [$clog2(DEPTH)-1:0] ptr_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [WORD_BITS-1:0]   word;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0] act;
        logic [WORD_BITS-1:0]   val;
        logic                   has_exp;
        logic [STATUS_BITS-1:0] st;
        logic [WORD_BITS-1:0]   wd;
    } stim_row_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} fill_mode_t;

    logic i_clk;
    logic i_rst_n;

    cded_cmd_if cmd_ch ();
    cded_res_if res_ch ();

    circular_double_ended_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    ptr_t                 front_ptr;
    ptr_t                 rear_ptr;
    bit                   deque_empty;
    logic [WORD_BITS-1:0] slot_mem [DEPTH];

    result_t step_results [$];
    result_t pending_results [$];
    int      error_count;
    int      results_taken;
    int      send_burst_left;
    int      take_burst_left;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{ACT_POP_REAR,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{ACT_SPARE_A,    32'h5555_5555, 1'b0, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_POP_REAR,   32'h0000_0000, 1'b1, ST_DONE,  32'h8000_0000},
        '{ACT_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_POP_FRONT,  32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h7FFF_FFFF},
        '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_REAR,  32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'h0000_0001, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_REAR,  32'hAAAA_AAAA, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'h5555_5555, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_REAR,  32'h1234_5678, 1'b1, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_REAR,  32'hDEAD_BEEF, 1'b1, ST_FULL,  32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'hCAFE_F00D, 1'b1, ST_FULL,  32'h0000_0000},
        '{ACT_SPARE_C,    32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
        '{ACT_POP_REAR,   32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
        '{ACT_SPARE_B,    32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
        '{ACT_PUSH_REAR,  32'h0F0F_0F0F, 1'b0, ST_DONE,  32'h0000_0000}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic ptr_t next_ptr(input ptr_t p);
        return ptr_t'((int'(p) + 1) % DEPTH);
    endfunction

    function automatic ptr_t prev_ptr(input ptr_t p);
        return ptr_t'((int'(p) + DEPTH - 1) % DEPTH);
    endfunction

    function automatic void predict_results(input logic [ACTION_BITS-1:0] act,
                                            input logic [WORD_BITS-1:0] val);
        ptr_t                 p;
        int                   n;
        bit                   fin;
        logic [WORD_BITS-1:0] w;
        step_results.delete();
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (!deque_empty && next_ptr(rear_ptr) == front_ptr) begin
                    step_results.push_back(result_t'{ST_FULL, '0, 1'b1});
                end else begin
                    if (deque_empty) begin
                        front_ptr   = '0;
                        rear_ptr    = '0;
                        deque_empty = 1'b0;
                        slot_mem[0] = val;
                    end else if (act == ACT_PUSH_FRONT) begin
                        front_ptr           = prev_ptr(front_ptr);
                        slot_mem[front_ptr] = val;
                    end else begin
                        rear_ptr           = next_ptr(rear_ptr);
                        slot_mem[rear_ptr] = val;
                    end
                    step_results.push_back(result_t'{ST_DONE, '0, 1'b1});
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
                if (deque_empty) begin
                    step_results.push_back(result_t'{ST_EMPTY, '0, 1'b1});
                end else begin
                    w = slot_mem[(act == ACT_POP_FRONT) ? front_ptr : rear_ptr];
                    if (front_ptr == rear_ptr) begin
                        front_ptr   = '0;
                        rear_ptr    = '0;
                        deque_empty = 1'b1;
                    end else if (act == ACT_POP_FRONT) begin
                        front_ptr = next_ptr(front_ptr);
                    end else begin
                        rear_ptr = prev_ptr(rear_ptr);
                    end
                    step_results.push_back(result_t'{ST_DONE, w, 1'b1});
                end
            end
            ACT_READ_ALL: begin
                if (deque_empty) begin
                    step_results.push_back(result_t'{ST_EMPTY, '0, 1'b1});
                end else begin
                    p   = front_ptr;
                    n   = 0;
                    fin = 1'b0;
                    while (!fin) begin
                        fin = (p == rear_ptr) || (n == DEPTH - 1);
                        step_results.push_back(result_t'{ST_DONE, slot_mem[p], fin});
                        n++;
                        p = next_ptr(p);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_gap(inout int burst_left);
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) burst_left = 20;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic offer_item(input logic [ACTION_BITS-1:0] act,
                              input logic [WORD_BITS-1:0] val,
                              input bit has_exp, input result_t exp_res);
        int gap;
        gap = draw_gap(send_burst_left);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= act;
        cmd_ch.push_value <= val;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_results(act, val);
        if (has_exp) begin
            pending_results.push_back(exp_res);
        end else begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
    endtask

    // take results, with one long hold-off to back the block up
    initial begin
        int      gap;
        result_t exp_res;
        res_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(take_burst_left);
            if (results_taken == HOLD_AT_RESULT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            results_taken++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status %0d word %h last %0b",
                         $time, res_ch.status, res_ch.word, res_ch.last);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (res_ch.status !== exp_res.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, exp_res.status, res_ch.status);
                    error_count++;
                end
                if (res_ch.word !== exp_res.word) begin
                    $display("%0t: word mismatch, expected %h actual %h",
                             $time, exp_res.word, res_ch.word);
                    error_count++;
                end
                if (res_ch.last !== exp_res.last) begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, exp_res.last, res_ch.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int                     issued;
        int                     r;
        int                     push_pct;
        fill_mode_t             mode;
        logic [ACTION_BITS-1:0] act;
        logic [WORD_BITS-1:0]   val;
        i_clk             = 1'b0;
        error_count       = 0;
        results_taken     = 0;
        send_burst_left   = 0;
        take_burst_left   = 0;
        front_ptr         = '0;
        rear_ptr          = '0;
        deque_empty       = 1'b1;
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.action     <= ACT_PUSH_FRONT;
        cmd_ch.push_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].act, directed_rows[i].val, directed_rows[i].has_exp,
                       result_t'{directed_rows[i].st, directed_rows[i].wd, 1'b1});
        end

        issued = 0;
        mode   = MODE_MIXED;
        while (issued < RANDOM_ITEMS) begin
            if (issued % MODE_SPAN == 0) mode = fill_mode_t'($urandom_range(0, 2));
            push_pct = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 25 : 40;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                act = ACTION_BITS'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
            end else if (r < 3 + push_pct) begin
                act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
                issued++;
            end else if (r < 88) begin
                act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
                issued++;
            end else begin
                act = ACT_READ_ALL;
                issued++;
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7FFF_FFFF;
                    2:       val = 32'h0000_0000;
                    default: val = 32'hFFFF_FFFF;
                endcase
            end else begin
                val = $urandom();
            end
            offer_item(act, val, 1'b0, result_t'{ST_DONE, '0, 1'b0});
        end
        cmd_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("circular_double_ended_queue_tb OK");
        end else begin
            $display("circular_double_ended_queue_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("circular_double_ended_queue_tb NOT OK");
        $finish;
    end
endmodule

// ===== circular_double_ended_queue.f =====
+incdir+src
src/cded_pkg.sv
src/cded_if.sv
src/cded_step.sv
src/cded_store.sv
src/circular_double_ended_queue.sv
bench/circular_double_ended_queue_tb.sv
